@@ rtl/core/imurlb_pkg.sv @@
// ----------------------------------------------------------------------------
// imurlb_pkg
// Shared types, widths and constants of the IMU sample conditioner: axis
// remap, acceleration low-pass and gyro bias tracking.
// ----------------------------------------------------------------------------
package imurlb_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int AXES       = 3;
  localparam int AX_W       = 2;
  localparam int UP_SH      = 8;
  localparam int ACC_W      = SAMPLE_W + UP_SH;
  localparam int DIFF_W     = ACC_W + 1;
  localparam int UPD_W      = ACC_W + 2;

  localparam int MAP_W      = 9;
  localparam int NEG_BIT    = 2 * AXES;
  localparam int CUT_W      = 14;
  localparam int LIMIT_W    = 23;
  localparam int LEARN_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int DT_IN_W    = 20;
  localparam int DT_W       = 16;
  localparam int P_W        = 30;
  localparam int GAIN_W     = 19;
  localparam int GAIN_SH    = 16;
  localparam int X_W        = 33;
  localparam int ALPHA_W    = 24;
  localparam int DEN_W      = X_W + 1;
  localparam int REM_W      = DEN_W + 1;

  localparam int MUL_A_W    = DIFF_W;
  localparam int MUL_B_W    = ALPHA_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int NORM_W     = 2 * SAMPLE_W + 2;
  localparam int CNT_W      = 5;

  localparam logic [GAIN_W-1:0]  GAIN_Q40 = GAIN_W'(431777);
  localparam logic [DT_IN_W-1:0] DT_MIN   = DT_IN_W'(10);
  localparam logic [DT_IN_W-1:0] DT_MAX   = DT_IN_W'(50000);
  localparam logic [DEN_W-1:0]   DEN_ONE  = DEN_W'(1) << ALPHA_W;

  localparam logic [CNT_W-1:0] CNT_AXES    = CNT_W'(AXES);
  localparam logic [CNT_W-1:0] CNT_LIMIT   = CNT_W'(AXES);
  localparam logic [CNT_W-1:0] CNT_NORM_CMP = CNT_W'(AXES + 1);
  localparam logic [CNT_W-1:0] CNT_ALPHA_P = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_ALPHA_X = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ALPHA_D = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_DIV_END = CNT_W'(ALPHA_W - 1);

  localparam logic [1:0] SEL_ZERO = 2'd3;

  localparam logic [MAP_W-1:0]   MAP_RST   = MAP_W'(36);
  localparam logic [CUT_W-1:0]   CUT_RST   = CUT_W'(320);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1638);
  localparam logic [LEARN_W-1:0] LEARN_RST = LEARN_W'(66);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [AXES-1:0]         vec_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef acc_t [AXES-1:0]            accv_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_EN  = 3'd0,
    CFG_AXIS_MAP   = 3'd1,
    CFG_CUTOFF     = 3'd2,
    CFG_RATE_LIMIT = 3'd3,
    CFG_LEARN_RATE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ALPHA,
    S_DIV,
    S_LPF,
    S_BIAS,
    S_DONE
  } state_t;

  // floor(d / 256) saturated to the sample range
  function automatic sample_t sat_shift(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] s;
    sample_t r;
    s = d >>> UP_SH;
    if (s[DIFF_W-1:SAMPLE_W-1] == '0 || s[DIFF_W-1:SAMPLE_W-1] == '1) begin
      r = s[SAMPLE_W-1:0];
    end else if (s[DIFF_W-1]) begin
      r = SAMPLE_MIN;
    end else begin
      r = SAMPLE_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/imurlb_remap.sv @@
// ----------------------------------------------------------------------------
// imurlb_remap
// Signed axis permutation of one three-axis vector: per output axis a source
// select (or zero) and an optional negation that saturates.
// ----------------------------------------------------------------------------
module imurlb_remap import imurlb_pkg::*; (
  input  logic [MAP_W-1:0] axis_map,
  input  vec_t             src,
  output vec_t             dst
);

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    logic [1:0] sel;
    sample_t    pick;

    assign sel  = axis_map[2*i +: 2];
    assign pick = (sel == SEL_ZERO) ? SAMPLE_W'(0) : src[sel];
    assign dst[i] = !axis_map[NEG_BIT+i] ? pick :
                    (pick == SAMPLE_MIN) ? SAMPLE_MAX : -pick;
  end

endmodule

@@ rtl/core/imu_axis_remap_lowpass_bias_core.sv @@
// ----------------------------------------------------------------------------
// imu_axis_remap_lowpass_bias_core
// IMU sample conditioner: axis remap, first-order acceleration low-pass and
// gyro bias tracking, on one shared multiplier and a radix-2 divider.
// Flow: with filtering off an accepted item goes straight to the done state;
//   with filtering on it passes norm, alpha, divide, low-pass and bias (the
//   first filtered item skips alpha and the low-pass update).
// Occupancy: one item at a time; the 24-step alpha divide and the sequence of
//   twelve multiplies on the single multiplier set how long each item takes.
// Reset: synchronous active-low; registers to reset values, filter unloaded,
//   bias zero.
// ----------------------------------------------------------------------------
module imu_axis_remap_lowpass_bias_core import imurlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               in_acc_x,
  input  sample_t               in_acc_y,
  input  sample_t               in_acc_z,
  input  sample_t               in_rate_x,
  input  sample_t               in_rate_y,
  input  sample_t               in_rate_z,
  input  logic [DT_IN_W-1:0]    in_elapsed_us,

  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               out_filt_acc_x,
  output sample_t               out_filt_acc_y,
  output sample_t               out_filt_acc_z,
  output sample_t               out_corr_rate_x,
  output sample_t               out_corr_rate_y,
  output sample_t               out_corr_rate_z,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic                filter_en_r;
  logic [MAP_W-1:0]    axis_map_r;
  logic [CUT_W-1:0]    cutoff_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LEARN_W-1:0]  learn_rate_r;

  // control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                lp_loaded_r, lp_loaded_nxt;
  logic                fen_r, fen_nxt;
  logic                learn_ok_r, learn_ok_nxt;

  // datapath
  vec_t                acc_r, acc_nxt;
  vec_t                rate_r, rate_nxt;
  logic [DT_W-1:0]     dt_r, dt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [NORM_W-1:0]   norm_r, norm_nxt;
  logic [ALPHA_W-1:0]  q_r, q_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  accv_t               lp_r, lp_nxt;
  accv_t               bias_r, bias_nxt;
  acc_t                base_r, base_nxt;
  logic                neg_r, neg_nxt;
  vec_t                oacc_r, oacc_nxt;
  vec_t                orate_r, orate_nxt;

  vec_t                acc_map, rate_map;
  logic                accept;
  logic                out_load;
  logic [AX_W-1:0]     ax_iss, ax_wr;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  sample_t             iss_smp;
  acc_t                iss_up, iss_base;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   diff_mag;
  sample_t             rate_sel;
  logic [SAMPLE_W-1:0] rate_mag;
  logic [ACC_W-1:0]    upd_q;
  logic [UPD_W-1:0]    upd_sum;
  logic [REM_W-1:0]    rem_sh;
  logic [X_W-1:0]      x24;
  logic [DT_IN_W-1:0]  dt_clamp;

  imurlb_remap u_remap_acc (
    .axis_map (axis_map_r),
    .src      ({in_acc_z, in_acc_y, in_acc_x}),
    .dst      (acc_map)
  );

  imurlb_remap u_remap_rate (
    .axis_map (axis_map_r),
    .src      ({in_rate_z, in_rate_y, in_rate_x}),
    .dst      (rate_map)
  );

  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign ax_iss   = (cnt_r[AX_W-1:0] == SEL_ZERO) ? AX_W'(0) : cnt_r[AX_W-1:0];
  assign ax_wr    = cnt_r[AX_W-1:0] - AX_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = filter_en_r ? S_NORM : S_DONE;
      S_NORM:  if (cnt_r == CNT_NORM_CMP) state_nxt = lp_loaded_r ? S_ALPHA : S_BIAS;
      S_ALPHA: if (cnt_r == CNT_ALPHA_D) state_nxt = S_DIV;
      S_DIV:   if (cnt_r == CNT_DIV_END) state_nxt = S_LPF;
      S_LPF:   if (cnt_r == CNT_AXES) state_nxt = S_BIAS;
      S_BIAS:  if (cnt_r == CNT_AXES) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and multiplier operands
  always_comb begin
    in_ready = (state_r == S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_NORM: begin
        if (cnt_r == CNT_LIMIT) begin
          mul_a = MUL_A_W'(limit_r);
          mul_b = MUL_B_W'(limit_r);
        end else begin
          mul_a = MUL_A_W'(rate_mag);
          mul_b = MUL_B_W'(rate_mag);
        end
      end
      S_ALPHA: begin
        if (cnt_r == CNT_ALPHA_P) begin
          mul_a = MUL_A_W'(dt_r);
          mul_b = MUL_B_W'(cutoff_r);
        end else begin
          mul_a = MUL_A_W'(prod_r[P_W-1:0]);
          mul_b = MUL_B_W'(GAIN_Q40);
        end
      end
      S_LPF: begin
        mul_a = diff_mag;
        mul_b = q_r;
      end
      S_BIAS: begin
        mul_a = diff_mag;
        mul_b = MUL_B_W'(learn_rate_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // issue side: difference of the selected axis against its state
  always_comb begin
    rate_sel = $signed(rate_r[ax_iss]);
    rate_mag = rate_sel[SAMPLE_W-1] ? SAMPLE_W'(-rate_sel) : rate_sel;
    iss_smp  = (state_r == S_LPF) ? $signed(acc_r[ax_iss]) : rate_sel;
    iss_up   = {iss_smp, {UP_SH{1'b0}}};
    iss_base = (state_r == S_LPF) ? $signed(lp_r[ax_iss]) : $signed(bias_r[ax_iss]);
    diff     = {iss_up[ACC_W-1], iss_up} - {iss_base[ACC_W-1], iss_base};
    diff_mag = diff[DIFF_W-1] ? -diff : diff;
  end

  // consume side: state update from the registered product
  always_comb begin
    upd_q   = (state_r == S_LPF) ? prod_r[ALPHA_W +: ACC_W] : prod_r[LEARN_W +: ACC_W];
    upd_sum = {{2{base_r[ACC_W-1]}}, base_r} +
              (neg_r ? -{2'b00, upd_q} : {2'b00, upd_q});
    rem_sh  = {rem_r[REM_W-2:0], 1'b0};
    x24     = prod_r[GAIN_SH +: X_W];
    if (in_elapsed_us < DT_MIN) begin
      dt_clamp = DT_MIN;
    end else if (in_elapsed_us > DT_MAX) begin
      dt_clamp = DT_MAX;
    end else begin
      dt_clamp = in_elapsed_us;
    end
  end

  // datapath next values
  always_comb begin
    cnt_nxt       = cnt_r + CNT_W'(1);
    out_valid_nxt = out_valid_r && !out_ready;
    lp_loaded_nxt = lp_loaded_r;
    fen_nxt       = fen_r;
    learn_ok_nxt  = learn_ok_r;
    acc_nxt       = acc_r;
    rate_nxt      = rate_r;
    dt_nxt        = dt_r;
    prod_nxt      = mul_a * mul_b;
    norm_nxt      = norm_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    lp_nxt        = lp_r;
    bias_nxt      = bias_r;
    base_nxt      = iss_base;
    neg_nxt       = diff[DIFF_W-1];
    oacc_nxt      = oacc_r;
    orate_nxt     = orate_r;

    if (state_nxt != state_r) begin
      cnt_nxt = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          acc_nxt  = acc_map;
          rate_nxt = rate_map;
          dt_nxt   = dt_clamp[DT_W-1:0];
          fen_nxt  = filter_en_r;
          norm_nxt = '0;
        end
      end
      S_NORM: begin
        if (cnt_r != '0 && cnt_r <= CNT_AXES) begin
          norm_nxt = norm_r + NORM_W'(prod_r[2*SAMPLE_W-1:0]);
        end
        if (cnt_r == CNT_NORM_CMP) begin
          learn_ok_nxt = norm_r < NORM_W'(prod_r[2*LIMIT_W-1:0]);
          if (!lp_loaded_r) begin
            lp_loaded_nxt = 1'b1;
            for (int i = 0; i < AXES; i++) begin
              lp_nxt[i] = {acc_r[i], {UP_SH{1'b0}}};
            end
          end
        end
      end
      S_ALPHA: begin
        if (cnt_r == CNT_ALPHA_D) begin
          rem_nxt = REM_W'(x24);
          den_nxt = DEN_ONE + DEN_W'(x24);
          q_nxt   = '0;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b0};
        end
      end
      S_LPF: begin
        if (cnt_r != '0) begin
          lp_nxt[ax_wr] = upd_sum[ACC_W-1:0];
        end
      end
      S_BIAS: begin
        if (cnt_r != '0 && learn_ok_r) begin
          bias_nxt[ax_wr] = upd_sum[ACC_W-1:0];
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          for (int i = 0; i < AXES; i++) begin
            if (fen_r) begin
              oacc_nxt[i]  = lp_r[i][ACC_W-1:UP_SH];
              orate_nxt[i] = sat_shift({rate_r[i][SAMPLE_W-1], rate_r[i], {UP_SH{1'b0}}} -
                                       {bias_r[i][ACC_W-1], bias_r[i]});
            end else begin
              oacc_nxt[i]  = acc_r[i];
              orate_nxt[i] = rate_r[i];
            end
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r  <= 1'b0;
      axis_map_r   <= MAP_RST;
      cutoff_r     <= CUT_RST;
      limit_r      <= LIMIT_RST;
      learn_rate_r <= LEARN_RST;
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      lp_loaded_r  <= 1'b0;
      fen_r        <= 1'b0;
      learn_ok_r   <= 1'b0;
      lp_r         <= '0;
      bias_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILTER_EN:  filter_en_r  <= cfg_data[0];
          CFG_AXIS_MAP:   axis_map_r   <= cfg_data[MAP_W-1:0];
          CFG_CUTOFF:     cutoff_r     <= cfg_data[CUT_W-1:0];
          CFG_RATE_LIMIT: limit_r      <= cfg_data[LIMIT_W-1:0];
          CFG_LEARN_RATE: learn_rate_r <= cfg_data[LEARN_W-1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      lp_loaded_r <= lp_loaded_nxt;
      fen_r       <= fen_nxt;
      learn_ok_r  <= learn_ok_nxt;
      lp_r        <= lp_nxt;
      bias_r      <= bias_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    rate_r  <= rate_nxt;
    dt_r    <= dt_nxt;
    prod_r  <= prod_nxt;
    norm_r  <= norm_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    base_r  <= base_nxt;
    neg_r   <= neg_nxt;
    oacc_r  <= oacc_nxt;
    orate_r <= orate_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_filt_acc_x  = oacc_r[0];
  assign out_filt_acc_y  = oacc_r[1];
  assign out_filt_acc_z  = oacc_r[2];
  assign out_corr_rate_x = orate_r[0];
  assign out_corr_rate_y = orate_r[1];
  assign out_corr_rate_z = orate_r[2];

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lp_loaded_r |=> lp_loaded_r)
    else $error("low-pass loaded flag dropped");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < {1'b0, den_r})
    else $error("divider remainder not below divisor");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done state");

endmodule

@@ test/tb_imu_axis_remap_lowpass_bias_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_axis_remap_lowpass_bias_core
// Self-checking bench for the IMU sample conditioner. Every accepted item is
// run through a fixed-point predictor of the axis remap, acceleration
// low-pass and gyro bias tracking; each result is compared field by field
// against the oldest prediction. Directed corners come first, then random
// phases under several register settings with random idling on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_imu_axis_remap_lowpass_bias_core;
  import imurlb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    vec_t                 acc;
    vec_t                 rate;
    logic [DT_IN_W-1:0]   elapsed;
  } imu_sample_t;

  typedef struct packed {
    vec_t acc;
    vec_t rate;
  } imu_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_ready;
  sample_t               in_acc_x, in_acc_y, in_acc_z;
  sample_t               in_rate_x, in_rate_y, in_rate_z;
  logic [DT_IN_W-1:0]    in_elapsed_us;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               out_filt_acc_x, out_filt_acc_y, out_filt_acc_z;
  sample_t               out_corr_rate_x, out_corr_rate_y, out_corr_rate_z;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers and filter state
  bit                m_en    = 1'b0;
  logic [MAP_W-1:0]  m_map   = MAP_RST;
  longint unsigned   m_cut   = CUT_RST;
  longint unsigned   m_limit = LIMIT_RST;
  longint unsigned   m_learn = LEARN_RST;
  longint            lp_state   [AXES] = '{default: 0};
  longint            bias_state [AXES] = '{default: 0};
  bit                lp_loaded = 1'b0;

  imu_result_t conditioned_q [$];
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int          rx_hold_cycles = 0;
  string       axis_tag [AXES] = '{"x", "y", "z"};

  imu_axis_remap_lowpass_bias_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_acc_x       (in_acc_x),
    .in_acc_y       (in_acc_y),
    .in_acc_z       (in_acc_z),
    .in_rate_x      (in_rate_x),
    .in_rate_y      (in_rate_y),
    .in_rate_z      (in_rate_z),
    .in_elapsed_us  (in_elapsed_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filt_acc_x (out_filt_acc_x),
    .out_filt_acc_y (out_filt_acc_y),
    .out_filt_acc_z (out_filt_acc_z),
    .out_corr_rate_x(out_corr_rate_x),
    .out_corr_rate_y(out_corr_rate_y),
    .out_corr_rate_z(out_corr_rate_z),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic longint clamp_sample(input longint v);
    if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
    return v;
  endfunction

  function automatic longint mul_trunc(input longint d, input longint unsigned w, input int sh);
    longint unsigned mag;
    longint unsigned p;
    if (d < 0) mag = -d;
    else mag = d;
    p = (mag * w) >> sh;
    if (d < 0) return -longint'(p);
    return longint'(p);
  endfunction

  function automatic vec_t remap_axes(input vec_t src);
    vec_t       dst;
    longint     v;
    logic [1:0] sel;
    for (int i = 0; i < AXES; i++) begin
      sel = m_map[AX_W*i +: AX_W];
      if (sel == SEL_ZERO) v = 0;
      else v = longint'(src[sel]);
      if (m_map[NEG_BIT+i]) v = -v;
      dst[i] = sample_t'(clamp_sample(v));
    end
    return dst;
  endfunction

  function automatic longint unsigned lowpass_alpha_q24(input logic [DT_IN_W-1:0] elapsed);
    longint unsigned dt;
    longint unsigned wdt;
    dt = elapsed;
    if (dt < DT_MIN) dt = DT_MIN;
    if (dt > DT_MAX) dt = DT_MAX;
    wdt = (dt * m_cut * GAIN_Q40) >> GAIN_SH;
    return (wdt << ALPHA_W) / ((64'd1 << ALPHA_W) + wdt);
  endfunction

  function automatic imu_result_t condition_sample(input imu_sample_t s);
    imu_result_t     r;
    vec_t            acc;
    vec_t            rate;
    longint unsigned alpha;
    longint unsigned norm2;
    longint unsigned mag;
    longint          rv;
    acc    = remap_axes(s.acc);
    rate   = remap_axes(s.rate);
    r.acc  = acc;
    r.rate = rate;
    if (m_en) begin
      if (!lp_loaded) begin
        for (int i = 0; i < AXES; i++) lp_state[i] = longint'(acc[i]) * 256;
        lp_loaded = 1'b1;
      end else begin
        alpha = lowpass_alpha_q24(s.elapsed);
        for (int i = 0; i < AXES; i++)
          lp_state[i] += mul_trunc(longint'(acc[i]) * 256 - lp_state[i], alpha, ALPHA_W);
      end
      for (int i = 0; i < AXES; i++) r.acc[i] = sample_t'(clamp_sample(lp_state[i] >>> UP_SH));

      norm2 = 0;
      for (int i = 0; i < AXES; i++) begin
        rv = longint'(rate[i]);
        if (rv < 0) mag = -rv;
        else mag = rv;
        norm2 += mag * mag;
      end
      // bias only learned while the unit sits still
      if (norm2 < m_limit * m_limit) begin
        for (int i = 0; i < AXES; i++)
          bias_state[i] += mul_trunc(longint'(rate[i]) * 256 - bias_state[i], m_learn, LEARN_W);
      end
      for (int i = 0; i < AXES; i++)
        r.rate[i] = sample_t'(clamp_sample((longint'(rate[i]) * 256 - bias_state[i]) >>> UP_SH));
    end
    return r;
  endfunction

  // ---------------- result checking ----------------

  task automatic check_field(input string name, input sample_t want, input sample_t seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    imu_result_t want;
    imu_result_t seen;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      seen.acc[0]  = out_filt_acc_x;
      seen.acc[1]  = out_filt_acc_y;
      seen.acc[2]  = out_filt_acc_z;
      seen.rate[0] = out_corr_rate_x;
      seen.rate[1] = out_corr_rate_y;
      seen.rate[2] = out_corr_rate_z;
      if (conditioned_q.size() == 0) begin
        $error("result item with no prediction pending");
        fail_count++;
      end else begin
        want = conditioned_q.pop_front();
        for (int i = 0; i < AXES; i++) begin
          check_field({"filt_acc_", axis_tag[i]}, want.acc[i], seen.acc[i]);
          check_field({"corr_rate_", axis_tag[i]}, want.rate[i], seen.rate[i]);
        end
      end
    end
  end

  // receiver: random stall before each item when enabled, optional long hold-off
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_sample(input imu_sample_t s);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_acc_x      <= s.acc[0];
    in_acc_y      <= s.acc[1];
    in_acc_z      <= s.acc[2];
    in_rate_x     <= s.rate[0];
    in_rate_y     <= s.rate[1];
    in_rate_z     <= s.rate[2];
    in_elapsed_us <= s.elapsed;
    do @(posedge clk); while (in_ready !== 1'b1);
    conditioned_q.push_back(condition_sample(s));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (conditioned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic apply_config(input bit en, input int unsigned map, cut, lim, learn);
    m_en    = en;
    m_map   = MAP_W'(map);
    m_cut   = CUT_W'(cut);
    m_limit = LIMIT_W'(lim);
    m_learn = LEARN_W'(learn);
    write_reg(CFG_FILTER_EN, en);
    write_reg(CFG_AXIS_MAP, map);
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_RATE_LIMIT, lim);
    write_reg(CFG_LEARN_RATE, learn);
    cfg_we <= 1'b0;
  endtask

  function automatic imu_sample_t make_sample(input int ax, ay, az, rx, ry, rz,
                                              input int unsigned us);
    imu_sample_t s;
    s.acc[0]  = sample_t'(ax);
    s.acc[1]  = sample_t'(ay);
    s.acc[2]  = sample_t'(az);
    s.rate[0] = sample_t'(rx);
    s.rate[1] = sample_t'(ry);
    s.rate[2] = sample_t'(rz);
    s.elapsed = DT_IN_W'(us);
    return s;
  endfunction

  function automatic sample_t corner_value();
    case ($urandom_range(0, 3))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  // mostly plausible samples with rates around the still threshold
  function automatic imu_sample_t random_sample(input int unsigned lim);
    imu_sample_t s;
    int kind;
    int span;
    kind = $urandom_range(0, 9);
    span = (kind == 9) ? int'(lim) + 64 : int'(lim / 2);
    for (int i = 0; i < AXES; i++) begin
      case (kind)
        6, 7: begin
          s.acc[i]  = sample_t'($urandom);
          s.rate[i] = sample_t'($urandom);
        end
        8: begin
          s.acc[i]  = corner_value();
          s.rate[i] = corner_value();
        end
        default: begin
          s.acc[i]  = sample_t'(int'($urandom_range(0, 524288)) - 262144);
          s.rate[i] = sample_t'(int'($urandom_range(0, 2 * span)) - span);
        end
      endcase
    end
    case ($urandom_range(0, 7))
      5: s.elapsed = DT_IN_W'($urandom_range(0, 20));
      6: s.elapsed = DT_IN_W'($urandom_range(49990, 50010));
      7: s.elapsed = DT_IN_W'($urandom);
      default: s.elapsed = DT_IN_W'($urandom_range(500, 2000));
    endcase
    return s;
  endfunction

  // ---------------- tests ----------------

  task automatic test_passthrough();
    apply_config(1'b0, MAP_RST, CUT_RST, LIMIT_RST, LEARN_RST);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 20'hFFFFF));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                            SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 1000));
    send_sample(make_sample(1, -1, 123456, -654321, 7, -7, 12345));
    wait_idle();
  endtask

  task automatic test_axis_map();
    int unsigned maps [5] = '{6, 484, 511, 0, 82};
    foreach (maps[k]) begin
      apply_config(1'b0, maps[k], CUT_RST, LIMIT_RST, LEARN_RST);
      send_sample(make_sample(SAMPLE_MIN, 100, SAMPLE_MAX, SAMPLE_MIN, -5, 77, 500));
      wait_idle();
    end
  endtask

  task automatic test_first_filtered();
    apply_config(1'b1, MAP_RST, CUT_RST, LIMIT_RST, LEARN_RST);
    // first filtered item loads the low-pass, elapsed time ignored
    send_sample(make_sample(100000, -200000, 321000, 500, -700, 300, 999999));
    send_sample(make_sample(120000, -190000, 320000, 600, -650, 250, 0));
    send_sample(make_sample(90000, -210000, 330000, 400, -600, 350, 20'hFFFFF));
    send_sample(make_sample(110000, -205000, 325000, 550, -720, 280, 50000));
    send_sample(make_sample(100000, -200000, 321000, 2000000, -1500000, 30000, 1000));
    wait_idle();
  endtask

  task automatic test_filter_extremes();
    apply_config(1'b1, MAP_RST, 16383, 8388607, 65535);
    send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                            2000000, -2000000, 2000000, 50000));
    send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                            SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 50000));
    send_sample(make_sample(SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MIN, 1, SAMPLE_MAX, 10));
    wait_idle();
    // cutoff zero holds the low-pass, limit zero stops learning
    apply_config(1'b1, MAP_RST, 0, 0, 0);
    send_sample(make_sample(5000, -5000, 300000, 10, -10, 0, 1000));
    send_sample(make_sample(-5000, 5000, -300000, 0, 0, 0, 50000));
    wait_idle();
    // learn rate zero while still
    apply_config(1'b1, 484, 1, 8388607, 0);
    send_sample(make_sample(7000, 8000, 9000, 100, 200, -300, 1000));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int unsigned map, cut, lim, learn;
    bit en;
    for (int p = 0; p < 8; p++) begin
      en = (p != 2) && (p != 5);
      map = (p == 0) ? MAP_RST : $urandom_range(0, 511);
      case ($urandom_range(0, 4))
        0: cut = 0;
        1: cut = 16383;
        2: cut = $urandom_range(1, 16383);
        default: cut = $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 4))
        0: lim = 0;
        1: lim = 8388607;
        default: lim = $urandom_range(200, 300000);
      endcase
      case ($urandom_range(0, 4))
        0: learn = 0;
        1: learn = 65535;
        default: learn = $urandom_range(1, 4000);
      endcase
      tx_idle_en = (p % 4 != 1) && (p % 4 != 3);
      rx_idle_en = (p % 4 != 2) && (p % 4 != 3);
      apply_config(en, map, cut, lim, learn);
      repeat (200) send_sample(random_sample(lim));
      wait_idle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    apply_config(1'b1, MAP_RST, CUT_RST, 20000, 2000);
    tx_idle_en = 1'b0;
    rx_hold_cycles = 600;
    repeat (30) send_sample(random_sample(20000));
    wait_idle();
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_acc_x      <= '0;
    in_acc_y      <= '0;
    in_acc_z      <= '0;
    in_rate_x     <= '0;
    in_rate_y     <= '0;
    in_rate_z     <= '0;
    in_elapsed_us <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_FILTER_EN;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_axis_map();
    test_first_filtered();
    test_filter_extremes();
    test_random_phases();
    test_backpressure();

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
